[rtl/core/rpac_pkg.sv]
// shared types, widths and constants of the point rotation pipeline
package rpac_pkg;

    localparam int ANGLE_W = 19;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + 32;
    localparam int GUARD   = 16;
    localparam int XW      = 52;
    localparam int ZW      = 34;
    localparam int ZCW     = 42;
    localparam int SUM_W   = XW - GUARD + 2;
    localparam int TABLE_LEN = 30;

    localparam int IN_W  = 152;
    localparam int OUT_W = 72;

    localparam logic signed [31:0] KINV_Q30 = 32'sh26DD3B6A;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sh0C90FDAA2;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sh06487ED51;

    typedef struct packed {
        logic signed [XW-1:0]      x;
        logic signed [XW-1:0]      y;
        logic signed [ZW-1:0]      z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } cell_t;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'h3243F6A9;
            1:  val = 32'h1DAC6705;
            2:  val = 32'h0FADBAFD;
            3:  val = 32'h07F56EA7;
            4:  val = 32'h03FEAB77;
            5:  val = 32'h01FFD55C;
            6:  val = 32'h00FFFAAB;
            7:  val = 32'h007FFF55;
            8:  val = 32'h003FFFEB;
            9:  val = 32'h001FFFFD;
            10: val = 32'h00100000;
            11: val = 32'h00080000;
            12: val = 32'h00040000;
            13: val = 32'h00020000;
            14: val = 32'h00010000;
            15: val = 32'h00008000;
            16: val = 32'h00004000;
            17: val = 32'h00002000;
            18: val = 32'h00001000;
            19: val = 32'h00000800;
            20: val = 32'h00000400;
            21: val = 32'h00000200;
            22: val = 32'h00000100;
            23: val = 32'h00000080;
            24: val = 32'h00000040;
            25: val = 32'h00000020;
            26: val = 32'h00000010;
            27: val = 32'h00000008;
            28: val = 32'h00000004;
            29: val = 32'h00000002;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

[rtl/core/rpac_prescale.sv]
// front end: center offset, gain prescale, angle clamp and quadrant fold
module rpac_prescale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  logic signed [rpac_pkg::ANGLE_W-1:0] angle,
    input  logic signed [rpac_pkg::COORD_W-1:0] px,
    input  logic signed [rpac_pkg::COORD_W-1:0] py,
    input  logic signed [rpac_pkg::COORD_W-1:0] center_x,
    input  logic signed [rpac_pkg::COORD_W-1:0] center_y,
    output logic                            out_valid,
    output rpac_pkg::cell_t                 out_data
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int RSH = 30 - rpac_pkg::GUARD;

    // stage 1: offsets and clamped angle
    logic                                  v1_reg;
    logic signed [rpac_pkg::DIFF_W-1:0]    dx_reg, dy_reg;
    logic signed [rpac_pkg::ZW-1:0]        z1_reg;
    logic signed [rpac_pkg::COORD_W-1:0]   cx1_reg, cy1_reg;
    logic signed [rpac_pkg::DIFF_W-1:0]    dx_next, dy_next;
    logic signed [rpac_pkg::ZCW-1:0]       zw;
    logic signed [rpac_pkg::ZW-1:0]        z1_next;

    // stage 2: prescaled products
    logic                                  v2_reg;
    logic signed [rpac_pkg::PROD_W-1:0]    mx_reg, my_reg;
    logic signed [rpac_pkg::ZW-1:0]        z2_reg;
    logic signed [rpac_pkg::COORD_W-1:0]   cx2_reg, cy2_reg;
    logic signed [rpac_pkg::PROD_W-1:0]    mx_next, my_next;

    // stage 3: rounded start vector after quadrant fold
    logic                                  v3_reg;
    rpac_pkg::cell_t                       d3_reg;
    rpac_pkg::cell_t                       d3_next;
    logic signed [rpac_pkg::PROD_W-1:0]    rx_sum, ry_sum;
    logic signed [rpac_pkg::XW-1:0]        x0, y0;

    localparam logic signed [rpac_pkg::ZCW-1:0] PI_W =
        rpac_pkg::ZCW'(rpac_pkg::PI_Q30);

    always_comb begin
        dx_next = rpac_pkg::DIFF_W'(px) - rpac_pkg::DIFF_W'(center_x);
        dy_next = rpac_pkg::DIFF_W'(py) - rpac_pkg::DIFF_W'(center_y);
        zw = rpac_pkg::ZCW'(angle) <<< SH;
        if (zw > PI_W) begin
            z1_next = rpac_pkg::PI_Q30;
        end else if (zw < -PI_W) begin
            z1_next = -rpac_pkg::PI_Q30;
        end else begin
            z1_next = rpac_pkg::ZW'(zw);
        end
    end

    always_comb begin
        mx_next = rpac_pkg::PROD_W'(dx_reg) * rpac_pkg::PROD_W'(rpac_pkg::KINV_Q30);
        my_next = rpac_pkg::PROD_W'(dy_reg) * rpac_pkg::PROD_W'(rpac_pkg::KINV_Q30);
    end

    always_comb begin
        rx_sum = mx_reg + (rpac_pkg::PROD_W'(1) <<< (RSH - 1));
        ry_sum = my_reg + (rpac_pkg::PROD_W'(1) <<< (RSH - 1));
        x0 = rpac_pkg::XW'(rx_sum >>> RSH);
        y0 = rpac_pkg::XW'(ry_sum >>> RSH);
        d3_next.cx = cx2_reg;
        d3_next.cy = cy2_reg;
        if (z2_reg > rpac_pkg::HALF_PI_Q30) begin
            d3_next.x = -y0;
            d3_next.y = x0;
            d3_next.z = z2_reg - rpac_pkg::HALF_PI_Q30;
        end else if (z2_reg < -rpac_pkg::HALF_PI_Q30) begin
            d3_next.x = y0;
            d3_next.y = -x0;
            d3_next.z = z2_reg + rpac_pkg::HALF_PI_Q30;
        end else begin
            d3_next.x = x0;
            d3_next.y = y0;
            d3_next.z = z2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            z1_reg  <= z1_next;
            cx1_reg <= center_x;
            cy1_reg <= center_y;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            z2_reg  <= z1_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            d3_reg  <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

[rtl/core/rpac_cell.sv]
// one micro-rotation cell of the rotation chain
module rpac_cell #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  logic            in_valid,
    input  rpac_pkg::cell_t in_data,
    output logic            out_valid,
    output rpac_pkg::cell_t out_data
);

    localparam logic signed [rpac_pkg::ZW-1:0] ATAN_STEP =
        rpac_pkg::ZW'(rpac_pkg::atan_q30(STEP));

    logic                           valid_reg;
    rpac_pkg::cell_t                data_reg;
    rpac_pkg::cell_t                data_next;
    logic signed [rpac_pkg::XW-1:0] x_in, y_in, xs, ys;
    logic signed [rpac_pkg::ZW-1:0] z_in;

    always_comb begin
        x_in = in_data.x;
        y_in = in_data.y;
        z_in = in_data.z;
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        data_next.cx = in_data.cx;
        data_next.cy = in_data.cy;
        // zero residue turns in the positive direction
        if (!z_in[rpac_pkg::ZW-1]) begin
            data_next.x = x_in - ys;
            data_next.y = y_in + xs;
            data_next.z = z_in - ATAN_STEP;
        end else begin
            data_next.x = x_in + ys;
            data_next.y = y_in - xs;
            data_next.z = z_in + ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/rpac_post.sv]
// back end: guard-bit rounding, center add-back and saturation, output register
module rpac_post (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            ce,
    input  logic                            in_valid,
    input  rpac_pkg::cell_t                 in_data,
    output logic                            out_valid,
    output logic signed [rpac_pkg::COORD_W-1:0] rx,
    output logic signed [rpac_pkg::COORD_W-1:0] ry,
    output logic                            saturated
);

    localparam int SW = rpac_pkg::SUM_W;
    localparam logic signed [SW-1:0] MAXV = SW'(64'sh7FFFFFFF);
    localparam logic signed [SW-1:0] MINV = -SW'(64'sh80000000);

    logic                               valid_reg;
    logic signed [rpac_pkg::COORD_W-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic                               sat_reg, sat_next;
    logic signed [rpac_pkg::XW-1:0]     xr, yr;
    logic signed [SW-1:0]               sx, sy;
    logic                               hi_x, lo_x, hi_y, lo_y;

    always_comb begin
        xr = in_data.x + (rpac_pkg::XW'(1) <<< (rpac_pkg::GUARD - 1));
        yr = in_data.y + (rpac_pkg::XW'(1) <<< (rpac_pkg::GUARD - 1));
        sx = SW'(xr >>> rpac_pkg::GUARD) + SW'(in_data.cx);
        sy = SW'(yr >>> rpac_pkg::GUARD) + SW'(in_data.cy);
        hi_x = sx > MAXV;
        lo_x = sx < MINV;
        hi_y = sy > MAXV;
        lo_y = sy < MINV;
        if (hi_x) begin
            rx_next = 32'sh7FFFFFFF;
        end else if (lo_x) begin
            rx_next = 32'sh80000000;
        end else begin
            rx_next = rpac_pkg::COORD_W'(sx);
        end
        if (hi_y) begin
            ry_next = 32'sh7FFFFFFF;
        end else if (lo_y) begin
            ry_next = 32'sh80000000;
        end else begin
            ry_next = rpac_pkg::COORD_W'(sy);
        end
        sat_next = hi_x | lo_x | hi_y | lo_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign rx        = rx_reg;
    assign ry        = ry_reg;
    assign saturated = sat_reg;

endmodule

[rtl/core/rotate_point_about_center_top.sv]
// throughput: one point per cycle while the output is not stalled; three front-end
// stages, one cordic cell per micro-rotation and one output stage, all moving
// together on a common enable
// a result held on m_tdata stalls the whole pipeline until it is taken
// reset: synchronous active-low aresetn clears every stage valid bit; data is not reset
module rotate_point_about_center_top #(
    parameter int FRAC_BITS = 16,
    parameter int ROT_STEPS = 18
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // angle[18:0], px[50:19], py[82:51], center_x[114:83], center_y[146:115]
    input  logic [rpac_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // rx[31:0], ry[63:32], saturated[64]
    output logic [rpac_pkg::OUT_W-1:0]  m_tdata
);

    localparam int NSTEPS = (ROT_STEPS > rpac_pkg::TABLE_LEN) ? rpac_pkg::TABLE_LEN
                                                              : ROT_STEPS;

    logic                                ce;
    logic                                chain_valid [0:NSTEPS];
    rpac_pkg::cell_t                     chain_data  [0:NSTEPS];
    logic signed [rpac_pkg::COORD_W-1:0] rx, ry;
    logic                                saturated;

    // the pipeline advances whenever the output slot is free or being drained
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    rpac_prescale #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prescale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .angle     ($signed(s_tdata[18:0])),
        .px        ($signed(s_tdata[50:19])),
        .py        ($signed(s_tdata[82:51])),
        .center_x  ($signed(s_tdata[114:83])),
        .center_y  ($signed(s_tdata[146:115])),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
        rpac_cell #(
            .STEP(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    rpac_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (chain_valid[NSTEPS]),
        .in_data   (chain_data[NSTEPS]),
        .out_valid (m_tvalid),
        .rx        (rx),
        .ry        (ry),
        .saturated (saturated)
    );

    assign m_tdata = {7'b0, saturated, ry, rx};

endmodule
